@@ hdl/cspl_pkg.sv @@
// Shared widths, types and codes of the centripetal spline path smoother.
package cspl_pkg;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int CoordWidth = 32;
  localparam int FracBits   = 16;
  localparam int SampWidth  = 5;
  localparam int AccWidth   = CoordWidth + 8;
  // knots hold three square-rooted chord steps
  localparam int KnotWidth  = (CoordWidth + FracBits + 2) / 2 + 2;
  localparam int MulBWidth  = max2(KnotWidth, CoordWidth + 1);
  localparam int AluRaw     = max2(max2(AccWidth + KnotWidth + 2, 2 * CoordWidth + 2),
                                   CoordWidth + 1 + FracBits);
  localparam int AluWidth   = AluRaw + AluRaw % 2;
  localparam int RemWidth   = max2(MulBWidth + 1, AluWidth / 2 + 3);
  localparam int CountWidth = $clog2(AluWidth + 1);

  localparam logic [SampWidth-1:0] SamplesReset = 5'd10;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [CoordWidth:0]   cdiff_t;
  typedef logic        [CoordWidth:0]   cmag_t;
  typedef logic signed [AccWidth-1:0]   acc_t;
  typedef logic signed [AccWidth:0]     diff_t;
  typedef logic signed [AccWidth+1:0]   wide_t;
  typedef logic        [KnotWidth-1:0]  knot_t;
  typedef logic signed [KnotWidth:0]    sknot_t;
  typedef logic        [AluWidth-1:0]   word_t;
  typedef logic        [MulBWidth-1:0]  mulb_t;
  typedef logic        [RemWidth-1:0]   rem_t;
  typedef logic        [CountWidth-1:0] count_t;
  typedef logic        [SampWidth-1:0]  samp_t;

  typedef enum logic [1:0] {
    AluMul,
    AluDiv,
    AluSqrt
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [3:0] {
    SeqIdle,
    SeqSqX,
    SeqSqY,
    SeqRoot1,
    SeqRoot2,
    SeqTMul,
    SeqTDiv,
    SeqBlMul,
    SeqBlDiv,
    SeqBlFin,
    SeqEmit,
    SeqEndEmit
  } seq_state_t;

  typedef enum logic [2:0] {
    BlA1,
    BlA2,
    BlA3,
    BlB1,
    BlB2,
    BlC
  } blend_t;

endpackage

@@ hdl/centripetal_spline_path_smoother.sv @@
// Centripetal Catmull-Rom path smoother: window, sequencer and sample word register.
// Work: knot work a segment (per chord two multiplies, two roots), then per sample a
// multiply, a divide, twelve blends (a multiply and a divide each) and an emit.
// Input: points are taken only in idle, so each waits for the knot and sample work and the
// words owed for the last (an endpoint word too) on the one shared unit; output stalls add to it.
// Reset: empties the window count and output register and sets 10 samples a segment.
module centripetal_spline_path_smoother (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      point_valid,
  output logic                      point_ready,
  input  cspl_pkg::coord_t          point_x,
  input  cspl_pkg::coord_t          point_y,
  input  logic                      last_point,
  output logic                      sample_valid,
  input  logic                      sample_ready,
  output cspl_pkg::coord_t          sample_x,
  output cspl_pkg::coord_t          sample_y,
  output logic                      last_of_run,
  output logic                      path_end,
  input  logic                      cfg_wr_en,
  input  cspl_pkg::samp_t           cfg_wr_data
);

  cspl_pkg::seq_state_t state;
  cspl_pkg::seq_state_t state_next;
  cspl_pkg::alu_req_t   alu_req;
  cspl_pkg::word_t      alu_a;
  cspl_pkg::mulb_t      alu_b;
  cspl_pkg::word_t      alu_result;
  logic                 alu_done;
  logic                 pend;

  cspl_pkg::samp_t      spc;
  logic [1:0]           points_seen;
  logic [1:0]           n_saved;
  cspl_pkg::coord_t     w0x, w1x, w2x, w0y, w1y, w2y;
  cspl_pkg::coord_t     in_x, in_y;
  logic                 in_last;
  logic                 pe_flag;
  logic                 seg_b;

  // segment control points and knots
  cspl_pkg::coord_t     p0x, p1x, p2x, p3x, p0y, p1y, p2y, p3y;
  cspl_pkg::knot_t      tk1, tk2, tk3;
  cspl_pkg::knot_t      tval;
  logic [1:0]           ki;
  cspl_pkg::samp_t      k;
  cspl_pkg::blend_t     bi;
  logic                 axis;
  cspl_pkg::word_t      prod;
  cspl_pkg::acc_t       a1, a2, a3, b1, b2;
  cspl_pkg::coord_t     sx, sy;

  logic                 accept;
  logic                 slot_free;
  logic                 emit_wr;
  cspl_pkg::coord_t     emit_x, emit_y;
  logic                 emit_lor, emit_pe;
  logic                 k_last;

  // chord pair
  cspl_pkg::coord_t     ca_x, cb_x, ca_y, cb_y;
  cspl_pkg::cdiff_t     cdx, cdy;
  cspl_pkg::cmag_t      cmx, cmy;
  cspl_pkg::knot_t      kstep;

  // blend operands and result
  cspl_pkg::coord_t     q0, q1, q2, q3;
  cspl_pkg::acc_t       bl_a, bl_b;
  cspl_pkg::knot_t      bl_ta, bl_tb, bl_den;
  cspl_pkg::diff_t      bl_diff;
  cspl_pkg::sknot_t     bl_num;
  logic [cspl_pkg::AccWidth:0]  bl_magd;
  logic [cspl_pkg::KnotWidth:0] bl_magn;
  logic                 bl_neg;
  logic [cspl_pkg::AccWidth:0]  bl_cap;
  cspl_pkg::wide_t      bl_r;
  cspl_pkg::acc_t       bl_res;
  cspl_pkg::coord_t     bl_fin;

  cspl_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_result)
  );

  assign point_ready = (state == cspl_pkg::SeqIdle);
  assign accept      = point_valid && point_ready;
  assign slot_free   = !sample_valid || sample_ready;
  assign k_last      = (k == spc - 1'b1);

  // chord endpoints for knot step ki
  always_comb begin
    case (ki)
      2'd0: begin
        ca_x = p0x; cb_x = p1x; ca_y = p0y; cb_y = p1y;
      end
      2'd1: begin
        ca_x = p1x; cb_x = p2x; ca_y = p1y; cb_y = p2y;
      end
      default: begin
        ca_x = p2x; cb_x = p3x; ca_y = p2y; cb_y = p3y;
      end
    endcase
    cdx   = cspl_pkg::cdiff_t'(cb_x) - cspl_pkg::cdiff_t'(ca_x);
    cdy   = cspl_pkg::cdiff_t'(cb_y) - cspl_pkg::cdiff_t'(ca_y);
    cmx   = cdx[cspl_pkg::CoordWidth] ? -cdx : cdx;
    cmy   = cdy[cspl_pkg::CoordWidth] ? -cdy : cdy;
    // raise a zero step to one LSB
    kstep = (alu_result[cspl_pkg::KnotWidth-1:0] == '0) ? cspl_pkg::knot_t'(1)
                                                        : alu_result[cspl_pkg::KnotWidth-1:0];
  end

  // pyramid level operands for the current axis
  always_comb begin
    q0 = axis ? p0y : p0x;
    q1 = axis ? p1y : p1x;
    q2 = axis ? p2y : p2x;
    q3 = axis ? p3y : p3x;
    case (bi)
      cspl_pkg::BlA1: begin
        bl_a = cspl_pkg::acc_t'(q0); bl_b = cspl_pkg::acc_t'(q1); bl_ta = '0;  bl_tb = tk1;
      end
      cspl_pkg::BlA2: begin
        bl_a = cspl_pkg::acc_t'(q1); bl_b = cspl_pkg::acc_t'(q2); bl_ta = tk1; bl_tb = tk2;
      end
      cspl_pkg::BlA3: begin
        bl_a = cspl_pkg::acc_t'(q2); bl_b = cspl_pkg::acc_t'(q3); bl_ta = tk2; bl_tb = tk3;
      end
      cspl_pkg::BlB1: begin
        bl_a = a1; bl_b = a2; bl_ta = '0;  bl_tb = tk2;
      end
      cspl_pkg::BlB2: begin
        bl_a = a2; bl_b = a3; bl_ta = tk1; bl_tb = tk3;
      end
      default: begin
        bl_a = b1; bl_b = b2; bl_ta = tk1; bl_tb = tk2;
      end
    endcase
    bl_den  = bl_tb - bl_ta;
    bl_diff = cspl_pkg::diff_t'(bl_b) - cspl_pkg::diff_t'(bl_a);
    bl_num  = cspl_pkg::sknot_t'(tval) - cspl_pkg::sknot_t'(bl_ta);
    bl_magd = bl_diff[cspl_pkg::AccWidth] ? -bl_diff : bl_diff;
    bl_magn = bl_num[cspl_pkg::KnotWidth] ? -bl_num : bl_num;
    bl_neg  = bl_diff[cspl_pkg::AccWidth] ^ bl_num[cspl_pkg::KnotWidth];
    // cap the rounded quotient, add or take it off, then saturate
    if (prod > (cspl_pkg::word_t'(1) << cspl_pkg::AccWidth)) begin
      bl_cap = {1'b1, {cspl_pkg::AccWidth{1'b0}}};
    end else begin
      bl_cap = prod[cspl_pkg::AccWidth:0];
    end
    bl_r = bl_neg ? cspl_pkg::wide_t'(bl_a) - cspl_pkg::wide_t'({1'b0, bl_cap})
                  : cspl_pkg::wide_t'(bl_a) + cspl_pkg::wide_t'({1'b0, bl_cap});
    if (&bl_r[cspl_pkg::AccWidth+1:cspl_pkg::AccWidth-1] ||
        ~|bl_r[cspl_pkg::AccWidth+1:cspl_pkg::AccWidth-1]) begin
      bl_res = bl_r[cspl_pkg::AccWidth-1:0];
    end else if (bl_r[cspl_pkg::AccWidth+1]) begin
      bl_res = {1'b1, {(cspl_pkg::AccWidth - 1){1'b0}}};
    end else begin
      bl_res = {1'b0, {(cspl_pkg::AccWidth - 1){1'b1}}};
    end
    if (&bl_res[cspl_pkg::AccWidth-1:cspl_pkg::CoordWidth-1] ||
        ~|bl_res[cspl_pkg::AccWidth-1:cspl_pkg::CoordWidth-1]) begin
      bl_fin = bl_res[cspl_pkg::CoordWidth-1:0];
    end else if (bl_res[cspl_pkg::AccWidth-1]) begin
      bl_fin = {1'b1, {(cspl_pkg::CoordWidth - 1){1'b0}}};
    end else begin
      bl_fin = {1'b0, {(cspl_pkg::CoordWidth - 1){1'b1}}};
    end
  end

  // sequencer: next state, unit requests and sample words
  always_comb begin
    state_next    = state;
    alu_req.start = 1'b0;
    alu_req.op    = cspl_pkg::AluMul;
    alu_a         = '0;
    alu_b         = '0;
    emit_wr       = 1'b0;
    emit_x        = sx;
    emit_y        = sy;
    emit_lor      = 1'b0;
    emit_pe       = 1'b0;
    case (state)
      cspl_pkg::SeqIdle: begin
        if (accept) begin
          if (spc == '0) begin
            state_next = cspl_pkg::SeqEndEmit;
          end else if (points_seen >= 2'd2 || (last_point && points_seen != 2'd0)) begin
            state_next = cspl_pkg::SeqSqX;
          end else if (last_point) begin
            state_next = cspl_pkg::SeqEndEmit;
          end
        end
      end
      cspl_pkg::SeqSqX: begin
        alu_req.start = !pend;
        alu_a         = cspl_pkg::word_t'(cmx);
        alu_b         = cspl_pkg::mulb_t'(cmx);
        if (alu_done) begin
          state_next = cspl_pkg::SeqSqY;
        end
      end
      cspl_pkg::SeqSqY: begin
        alu_req.start = !pend;
        alu_a         = cspl_pkg::word_t'(cmy);
        alu_b         = cspl_pkg::mulb_t'(cmy);
        if (alu_done) begin
          state_next = cspl_pkg::SeqRoot1;
        end
      end
      cspl_pkg::SeqRoot1: begin
        alu_req.start = !pend;
        alu_req.op    = cspl_pkg::AluSqrt;
        alu_a         = prod;
        if (alu_done) begin
          state_next = cspl_pkg::SeqRoot2;
        end
      end
      cspl_pkg::SeqRoot2: begin
        alu_req.start = !pend;
        alu_req.op    = cspl_pkg::AluSqrt;
        alu_a         = prod << cspl_pkg::FracBits;
        if (alu_done) begin
          state_next = (ki == 2'd2) ? cspl_pkg::SeqTMul : cspl_pkg::SeqSqX;
        end
      end
      cspl_pkg::SeqTMul: begin
        alu_req.start = !pend;
        alu_a         = cspl_pkg::word_t'(tk2 - tk1);
        alu_b         = cspl_pkg::mulb_t'({k, 1'b0});
        if (alu_done) begin
          state_next = cspl_pkg::SeqTDiv;
        end
      end
      cspl_pkg::SeqTDiv: begin
        alu_req.start = !pend;
        alu_req.op    = cspl_pkg::AluDiv;
        alu_a         = prod + cspl_pkg::word_t'(spc);
        alu_b         = cspl_pkg::mulb_t'({spc, 1'b0});
        if (alu_done) begin
          state_next = cspl_pkg::SeqBlMul;
        end
      end
      cspl_pkg::SeqBlMul: begin
        alu_req.start = !pend;
        alu_a         = cspl_pkg::word_t'(bl_magd);
        alu_b         = cspl_pkg::mulb_t'(bl_magn);
        if (alu_done) begin
          state_next = cspl_pkg::SeqBlDiv;
        end
      end
      cspl_pkg::SeqBlDiv: begin
        alu_req.start = !pend;
        alu_req.op    = cspl_pkg::AluDiv;
        alu_a         = prod + cspl_pkg::word_t'(bl_den >> 1);
        alu_b         = cspl_pkg::mulb_t'(bl_den);
        if (alu_done) begin
          state_next = cspl_pkg::SeqBlFin;
        end
      end
      cspl_pkg::SeqBlFin: begin
        if (bi == cspl_pkg::BlC && axis) begin
          state_next = cspl_pkg::SeqEmit;
        end else begin
          state_next = cspl_pkg::SeqBlMul;
        end
      end
      cspl_pkg::SeqEmit: begin
        if (slot_free) begin
          emit_wr  = 1'b1;
          emit_lor = k_last && !in_last;
          if (!k_last) begin
            state_next = cspl_pkg::SeqTMul;
          end else if (!seg_b && in_last) begin
            state_next = cspl_pkg::SeqSqX;
          end else if (seg_b) begin
            state_next = cspl_pkg::SeqEndEmit;
          end else begin
            state_next = cspl_pkg::SeqIdle;
          end
        end
      end
      cspl_pkg::SeqEndEmit: begin
        emit_x   = in_x;
        emit_y   = in_y;
        emit_lor = 1'b1;
        emit_pe  = pe_flag;
        if (slot_free) begin
          emit_wr    = 1'b1;
          state_next = cspl_pkg::SeqIdle;
        end
      end
      default: begin
        state_next = cspl_pkg::SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cspl_pkg::SeqIdle;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      spc          <= cspl_pkg::SamplesReset;
      points_seen  <= 2'd0;
      sample_valid <= 1'b0;
    end else begin
      if (alu_req.start) begin
        pend <= 1'b1;
      end else if (alu_done) begin
        pend <= 1'b0;
      end
      if (cfg_wr_en) begin
        spc <= cfg_wr_data;
      end
      if (accept) begin
        if (last_point) begin
          points_seen <= 2'd0;
        end else if (points_seen != 2'd3) begin
          points_seen <= points_seen + 2'd1;
        end
      end
      if (emit_wr) begin
        sample_valid <= 1'b1;
      end else if (sample_ready) begin
        sample_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit_wr) begin
      sample_x    <= emit_x;
      sample_y    <= emit_y;
      last_of_run <= emit_lor;
      path_end    <= emit_pe;
    end
    if (accept) begin
      in_x    <= point_x;
      in_y    <= point_y;
      in_last <= last_point;
      n_saved <= points_seen;
      pe_flag <= (spc == '0) ? last_point : 1'b1;
      ki      <= 2'd0;
      k       <= '0;
      // shift the window unless the path closes here
      if (!last_point) begin
        w0x <= w1x; w1x <= w2x; w2x <= point_x;
        w0y <= w1y; w1y <= w2y; w2y <= point_y;
      end
      if (points_seen >= 2'd2) begin
        seg_b <= 1'b0;
        p0x <= (points_seen == 2'd3) ? w0x : w1x;
        p0y <= (points_seen == 2'd3) ? w0y : w1y;
        p1x <= w1x; p1y <= w1y;
        p2x <= w2x; p2y <= w2y;
        p3x <= point_x; p3y <= point_y;
      end else begin
        // closing segment, first point doubled as the lead-in tangent
        seg_b <= 1'b1;
        p0x <= w2x; p0y <= w2y;
        p1x <= w2x; p1y <= w2y;
        p2x <= point_x; p2y <= point_y;
        p3x <= point_x; p3y <= point_y;
      end
    end
    if (alu_done) begin
      prod <= (state == cspl_pkg::SeqSqY) ? prod + alu_result : alu_result;
    end
    if (state == cspl_pkg::SeqRoot2 && alu_done) begin
      case (ki)
        2'd0:    tk1 <= kstep;
        2'd1:    tk2 <= tk1 + kstep;
        default: tk3 <= tk2 + kstep;
      endcase
      ki <= ki + 2'd1;
    end
    if (state == cspl_pkg::SeqTDiv && alu_done) begin
      tval <= tk1 + alu_result[cspl_pkg::KnotWidth-1:0];
      bi   <= cspl_pkg::BlA1;
      axis <= 1'b0;
    end
    if (state == cspl_pkg::SeqBlFin) begin
      case (bi)
        cspl_pkg::BlA1: begin
          a1 <= bl_res; bi <= cspl_pkg::BlA2;
        end
        cspl_pkg::BlA2: begin
          a2 <= bl_res; bi <= cspl_pkg::BlA3;
        end
        cspl_pkg::BlA3: begin
          a3 <= bl_res; bi <= cspl_pkg::BlB1;
        end
        cspl_pkg::BlB1: begin
          b1 <= bl_res; bi <= cspl_pkg::BlB2;
        end
        cspl_pkg::BlB2: begin
          b2 <= bl_res; bi <= cspl_pkg::BlC;
        end
        default: begin
          if (axis) begin
            sy <= bl_fin;
          end else begin
            sx   <= bl_fin;
            axis <= 1'b1;
            bi   <= cspl_pkg::BlA1;
          end
        end
      endcase
    end
    if (state == cspl_pkg::SeqEmit && emit_wr) begin
      if (!k_last) begin
        k <= k + 1'b1;
      end else if (!seg_b && in_last) begin
        // advance to the closing segment; the window was held for it
        seg_b <= 1'b1;
        ki    <= 2'd0;
        k     <= '0;
        p0x   <= (n_saved >= 2'd2) ? w1x : w2x;
        p0y   <= (n_saved >= 2'd2) ? w1y : w2y;
        p1x   <= w2x; p1y <= w2y;
        p2x   <= in_x; p2y <= in_y;
        p3x   <= in_x; p3y <= in_y;
      end
    end
  end

endmodule

@@ hdl/cspl_alu.sv @@
// Shared iterative unit: shift-add multiply, restoring divide, restoring square root.
module cspl_alu (
  input  logic               clk,
  input  logic               rst,
  input  cspl_pkg::alu_req_t req,
  input  cspl_pkg::word_t    opa,
  input  cspl_pkg::mulb_t    opb,
  output logic               done,
  output cspl_pkg::word_t    result
);

  logic              busy;
  cspl_pkg::alu_op_t op_r;
  cspl_pkg::count_t  cnt;
  cspl_pkg::count_t  last_cnt;
  cspl_pkg::word_t   acc;
  cspl_pkg::word_t   acc_next;
  cspl_pkg::word_t   sh;
  cspl_pkg::word_t   sh_next;
  cspl_pkg::mulb_t   mb;
  cspl_pkg::mulb_t   mb_next;
  cspl_pkg::rem_t    rem;
  cspl_pkg::rem_t    rem_next;
  cspl_pkg::rem_t    rem_sh;
  cspl_pkg::rem_t    trial;

  assign result = acc;

  always_comb begin
    case (op_r)
      cspl_pkg::AluMul:  last_cnt = cspl_pkg::count_t'(cspl_pkg::MulBWidth - 1);
      cspl_pkg::AluDiv:  last_cnt = cspl_pkg::count_t'(cspl_pkg::AluWidth - 1);
      cspl_pkg::AluSqrt: last_cnt = cspl_pkg::count_t'(cspl_pkg::AluWidth / 2 - 1);
      default:           last_cnt = '0;
    endcase
  end

  always_comb begin
    acc_next = acc;
    sh_next  = sh;
    mb_next  = mb;
    rem_next = rem;
    rem_sh   = '0;
    trial    = '0;
    case (op_r)
      cspl_pkg::AluMul: begin
        if (mb[0]) begin
          acc_next = acc + sh;
        end
        sh_next = {sh[cspl_pkg::AluWidth-2:0], 1'b0};
        mb_next = {1'b0, mb[cspl_pkg::MulBWidth-1:1]};
      end
      cspl_pkg::AluDiv: begin
        rem_sh  = {rem[cspl_pkg::RemWidth-2:0], sh[cspl_pkg::AluWidth-1]};
        sh_next = {sh[cspl_pkg::AluWidth-2:0], 1'b0};
        trial   = {{(cspl_pkg::RemWidth - cspl_pkg::MulBWidth){1'b0}}, mb};
        if (rem_sh >= trial) begin
          rem_next = rem_sh - trial;
          acc_next = {acc[cspl_pkg::AluWidth-2:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          acc_next = {acc[cspl_pkg::AluWidth-2:0], 1'b0};
        end
      end
      cspl_pkg::AluSqrt: begin
        rem_sh  = {rem[cspl_pkg::RemWidth-3:0], sh[cspl_pkg::AluWidth-1:cspl_pkg::AluWidth-2]};
        sh_next = {sh[cspl_pkg::AluWidth-3:0], 2'b00};
        trial   = {acc[cspl_pkg::RemWidth-3:0], 2'b01};
        if (rem_sh >= trial) begin
          rem_next = rem_sh - trial;
          acc_next = {acc[cspl_pkg::AluWidth-2:0], 1'b1};
        end else begin
          rem_next = rem_sh;
          acc_next = {acc[cspl_pkg::AluWidth-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          busy <= 1'b1;
          op_r <= req.op;
          cnt  <= '0;
          acc  <= '0;
          rem  <= '0;
          sh   <= opa;
          mb   <= opb;
        end
      end else begin
        acc <= acc_next;
        sh  <= sh_next;
        mb  <= mb_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ tb/tb_centripetal_spline_path_smoother.sv @@
// Testbench for the centripetal spline path smoother: scoreboard, driving tasks and phases.
`timescale 1ns / 100ps

module tb_centripetal_spline_path_smoother;

  localparam int        ClkPeriod   = 8;
  localparam int        ResetCycles = 7;
  localparam int        DrainCycles = 3000;   // covers the longest silent step of the block
  localparam longint    CycleLimit  = 8_000_000;
  localparam longint    AccMax      = (64'sd1 <<< (cspl_pkg::AccWidth - 1)) - 1;
  localparam longint    CoordMax    = (64'sd1 <<< (cspl_pkg::CoordWidth - 1)) - 1;
  localparam int        RandomItems = 240;

  // one expected sample word
  typedef struct {
    cspl_pkg::coord_t x;
    cspl_pkg::coord_t y;
    logic             run_end;
    logic             closes;
  } sample_word_t;

  // Scoreboard: a bit-exact copy of the smoother's window and arithmetic, plus the
  // queue of sample words still owed by the block.
  class path_scoreboard;
    longint          win_x[3];
    longint          win_y[3];
    int unsigned     held;
    int unsigned     spacing;
    sample_word_t    owed[$];
    sample_word_t    burst[$];
    int              fails;

    function new();
      held    = 0;
      spacing = cspl_pkg::SamplesReset;
      fails   = 0;
      foreach (win_x[i]) begin
        win_x[i] = 0;
        win_y[i] = 0;
      end
    endfunction

    task report(input string what);
      fails++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    static function longint unsigned magn(input longint v);
      return (v < 0) ? longint'(-v) : v;
    endfunction

    static function longint clamp(input longint v, input longint hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    static function longint unsigned root(input logic [127:0] n);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ((128'(c) * 128'(c)) <= n) r = c;
      end
      return r;
    endfunction

    // knot step: square root of the chord length, floor of one LSB
    static function longint chord_knot(input longint xa, input longint ya,
                                       input longint xb, input longint yb);
      longint unsigned mx;
      longint unsigned my;
      longint unsigned len;
      longint unsigned k;
      mx  = magn(xb - xa);
      my  = magn(yb - ya);
      len = root(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
      k   = root(128'(len) << cspl_pkg::FracBits);
      return (k == 0) ? 1 : longint'(k);
    endfunction

    // a + (b - a) * (t - ta) / (tb - ta), rounded half away from zero
    static function longint mix(input longint a, input longint b, input longint ta,
                                input longint tb, input longint t);
      longint       den;
      longint       num;
      longint       diff;
      logic [127:0] prod;
      logic [127:0] quo;
      bit           neg;
      longint       r;
      den  = tb - ta;
      num  = t - ta;
      diff = b - a;
      if (den <= 0) return a;
      neg  = (diff < 0) != (num < 0);
      prod = 128'(magn(diff)) * 128'(magn(num));
      quo  = (prod + 128'(den >>> 1)) / 128'(den);
      if (quo > (128'd1 << cspl_pkg::AccWidth)) quo = 128'd1 << cspl_pkg::AccWidth;
      r = neg ? a - longint'(quo[63:0]) : a + longint'(quo[63:0]);
      return clamp(r, AccMax);
    endfunction

    static function longint pyramid(input longint p[4], input longint tk[4], input longint t);
      longint a1, a2, a3, b1, b2;
      a1 = mix(p[0], p[1], tk[0], tk[1], t);
      a2 = mix(p[1], p[2], tk[1], tk[2], t);
      a3 = mix(p[2], p[3], tk[2], tk[3], t);
      b1 = mix(a1, a2, tk[0], tk[2], t);
      b2 = mix(a2, a3, tk[1], tk[3], t);
      return clamp(mix(b1, b2, tk[1], tk[2], t), CoordMax);
    endfunction

    function void add_word(input longint x, input longint y, input logic closes);
      sample_word_t w;
      w.x       = cspl_pkg::coord_t'(x);
      w.y       = cspl_pkg::coord_t'(y);
      w.run_end = 1'b0;
      w.closes  = closes;
      burst.insert(burst.size(), w);
    endfunction

    function void sample_segment(input longint px[4], input longint py[4]);
      longint            tk[4];
      longint unsigned   span;
      longint unsigned   s;
      longint            t;
      tk[0] = 0;
      for (int i = 1; i < 4; i++)
        tk[i] = tk[i-1] + chord_knot(px[i-1], py[i-1], px[i], py[i]);
      span = longint'(tk[2] - tk[1]);
      s    = spacing;
      for (longint unsigned k = 0; k < s; k++) begin
        t = tk[1] + longint'((2 * k * span + s) / (2 * s));
        add_word(pyramid(px, tk, t), pyramid(py, tk, t), 1'b0);
      end
    endfunction

    // note an accepted control point and queue the words it owes
    function void note_point(input cspl_pkg::coord_t px_in, input cspl_pkg::coord_t py_in,
                             input logic last);
      longint x, y;
      longint px[4], py[4];
      x = px_in;
      y = py_in;
      burst.delete();
      if (spacing == 0) begin
        add_word(x, y, last);
      end else begin
        if (held >= 2) begin
          px = '{(held >= 3) ? win_x[0] : win_x[1], win_x[1], win_x[2], x};
          py = '{(held >= 3) ? win_y[0] : win_y[1], win_y[1], win_y[2], y};
          sample_segment(px, py);
        end
        if (last) begin
          if (held >= 1) begin
            px = '{(held >= 2) ? win_x[1] : win_x[2], win_x[2], x, x};
            py = '{(held >= 2) ? win_y[1] : win_y[2], win_y[2], y, y};
            sample_segment(px, py);
          end
          add_word(x, y, 1'b1);
        end
      end
      if (last) begin
        held = 0;
      end else begin
        win_x[0] = win_x[1]; win_y[0] = win_y[1];
        win_x[1] = win_x[2]; win_y[1] = win_y[2];
        win_x[2] = x;        win_y[2] = y;
        held = (held >= 3) ? 3 : held + 1;
      end
      if (burst.size() > 0) burst[burst.size()-1].run_end = 1'b1;
      foreach (burst[i]) owed.insert(owed.size(), burst[i]);
    endfunction

    task check_sample(input cspl_pkg::coord_t x, input cspl_pkg::coord_t y,
                      input logic run_end, input logic closes);
      sample_word_t w;
      if (owed.size() == 0) begin
        report($sformatf("unexpected sample (%0d,%0d)", x, y));
      end else begin
        w = owed.pop_front();
        if (x !== w.x || y !== w.y || run_end !== w.run_end || closes !== w.closes)
          report($sformatf("got (%0d,%0d,%b,%b) want (%0d,%0d,%b,%b)",
                           x, y, run_end, closes, w.x, w.y, w.run_end, w.closes));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             point_valid;
  logic             point_ready;
  cspl_pkg::coord_t point_x;
  cspl_pkg::coord_t point_y;
  logic             last_point;
  logic             sample_valid;
  logic             sample_ready;
  cspl_pkg::coord_t sample_x;
  cspl_pkg::coord_t sample_y;
  logic             last_of_run;
  logic             path_end;
  logic             cfg_wr_en;
  cspl_pkg::samp_t  cfg_wr_data;

  path_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  longint         cycles;

  centripetal_spline_path_smoother uut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .last_of_run  (last_of_run),
    .path_end     (path_end),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Watchdog: drop the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sample side: check each accepted word, then choose ready for the next cycle.
  // Values read here are those before this edge's updates, so there is no race.
  always @(posedge clk) begin
    if (!rst && sample_valid && sample_ready)
      sb.check_sample(sample_x, sample_y, last_of_run, path_end);
    sample_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Present one control point and hold it until the block takes it. Valid is only
  // lowered when a gap follows, so it never gets two assignments in one step.
  task send_point(input cspl_pkg::coord_t x, input cspl_pkg::coord_t y, input logic last);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      point_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    point_valid <= 1'b1;
    point_x     <= x;
    point_y     <= y;
    last_point  <= last;
    do @(posedge clk); while (!point_ready);
    sb.note_point(x, y, last);
  endtask

  // Wait for every owed word, let the block settle, then write the sample count.
  task set_spacing(input cspl_pkg::samp_t s);
    point_valid <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.spacing = s;
  endtask

  // Mostly nearby points so the curve stays meaningful; now and then a wild one,
  // an extreme or a repeat of the previous point.
  function automatic cspl_pkg::coord_t pick_coord(input cspl_pkg::coord_t prev);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return cspl_pkg::coord_t'($urandom);
    if (sel == 1)
      return $urandom_range(0, 1) ? cspl_pkg::coord_t'(CoordMax)
                                  : cspl_pkg::coord_t'(-CoordMax - 1);
    if (sel == 2) return prev;
    return prev + (cspl_pkg::coord_t'($urandom) >>> $urandom_range(8, 14));
  endfunction

  task random_path(input int len);
    cspl_pkg::coord_t x, y;
    x = cspl_pkg::coord_t'($urandom) >>> 4;
    y = cspl_pkg::coord_t'($urandom) >>> 4;
    for (int i = 0; i < len; i++) begin
      x = pick_coord(x);
      y = pick_coord(y);
      send_point(x, y, i == len - 1);
    end
  endtask

  initial begin
    int               sent;
    int               len;
    int               budget;
    cspl_pkg::samp_t  sp_list[12];
    sb             = new();
    cycles         = 0;
    rst            = 1'b1;
    point_valid    = 1'b0;
    point_x        = '0;
    point_y        = '0;
    last_point     = 1'b0;
    sample_ready   = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset spacing: single-point path, two-point path, extreme corners
    // that drive the blends into saturation, and coincident points.
    send_point(32'sd0, 32'sd0, 1'b1);
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sh0001_0000, -32'sh0000_8000, 1'b1);
    send_point(cspl_pkg::coord_t'(CoordMax), cspl_pkg::coord_t'(-CoordMax - 1), 1'b0);
    send_point(cspl_pkg::coord_t'(-CoordMax - 1), cspl_pkg::coord_t'(CoordMax), 1'b0);
    send_point(cspl_pkg::coord_t'(CoordMax), cspl_pkg::coord_t'(CoordMax), 1'b0);
    send_point(cspl_pkg::coord_t'(-CoordMax - 1), cspl_pkg::coord_t'(-CoordMax - 1), 1'b1);
    send_point(32'sd5, 32'sd5, 1'b0);
    send_point(32'sd5, 32'sd5, 1'b0);
    send_point(32'sd5, 32'sd5, 1'b1);

    // Zero spacing passes points straight through, window still advancing.
    set_spacing(cspl_pkg::samp_t'(0));
    send_point(-32'sd1, 32'sd7, 1'b0);
    send_point(32'sd3, -32'sd1, 1'b0);
    send_point(32'sh1234_5678, -32'sh0765_4321, 1'b1);

    // Largest spacing, then the smallest nonzero one, on short paths.
    set_spacing(cspl_pkg::samp_t'(31));
    send_point(32'sd0, 32'sd0, 1'b0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 1'b1);
    set_spacing(cspl_pkg::samp_t'(1));
    send_point(32'sh0002_0000, 32'sd0, 1'b0);
    send_point(32'sd0, 32'sh0002_0000, 1'b0);
    send_point(-32'sh0002_0000, 32'sd0, 1'b0);
    send_point(32'sd0, -32'sh0002_0000, 1'b1);

    // Random phases: cycle through the idling modes and a spread of spacings,
    // most of them small to keep the run short.
    sp_list = '{cspl_pkg::samp_t'(2), cspl_pkg::samp_t'(1), cspl_pkg::samp_t'(3),
                cspl_pkg::samp_t'(31), cspl_pkg::samp_t'(0), cspl_pkg::samp_t'(4),
                cspl_pkg::samp_t'(1), cspl_pkg::samp_t'(2), cspl_pkg::samp_t'(5),
                cspl_pkg::samp_t'(3), cspl_pkg::samp_t'(10), cspl_pkg::samp_t'(2)};
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      set_spacing(sp_list[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      budget = (sp_list[ph] > 8) ? 5 : RandomItems / 11;
      while (budget > 0) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
        if (len > budget) len = budget;
        random_path(len);
        budget -= len;
        sent   += len;
      end
    end

    // Hold until nothing is owed, then let the block go quiet.
    point_valid <= 1'b0;
    do @(posedge clk); while (sb.owed.size() != 0);
    repeat (DrainCycles) @(posedge clk);
    if (sb.owed.size() != 0) sb.report("samples still owed at the end");
    if (sb.fails == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
